### src/longest_prefix_match_table_top_assert.svh
// assertion macros for the longest prefix match table
`ifndef LONGEST_PREFIX_MATCH_TABLE_TOP_ASSERT_SVH
`define LONGEST_PREFIX_MATCH_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LPM_ASSERT(lbl, ck, rst_n, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) \
		else $error("lpm property violated");
`define LPM_NEVER(lbl, ck, rst_n, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) !(cond)) \
		else $error("lpm forbidden condition seen");
`else
`define LPM_ASSERT(lbl, ck, rst_n, prop)
`define LPM_NEVER(lbl, ck, rst_n, cond)
`endif
`endif

### src/lpm_pkg.sv
// shared types, codes and helpers of the longest prefix match table
package lpm_pkg;
	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_DEL    = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;
	localparam logic [1:0] MODE_GET    = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOTFOUND = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_EXISTED  = 3'd3;
	localparam logic [2:0] ST_DUP      = 3'd4;

	localparam logic [5:0] HOST_LEN = 6'd32;

	typedef struct packed {
		logic exact;
		logic covers;
	} match_t;

	function automatic logic [31:0] pfx_mask(input logic [5:0] len);
		logic [31:0] m;
		if (len == 6'd0) begin
			m = 32'd0;
		end else begin
			m = 32'hFFFF_FFFF << (HOST_LEN - len);
		end
		return m;
	endfunction
endpackage

### src/lpm_match.sv
// prefix compare unit shared by every step of the table scan
module lpm_match (
	input  logic [31:0]     ent_addr,
	input  logic [5:0]      ent_len,
	input  logic            ent_valid,
	input  logic [31:0]     key_addr,
	input  logic [5:0]      key_len,
	output lpm_pkg::match_t hit
);
	import lpm_pkg::*;

	logic [31:0] ent_mask;
	logic [31:0] key_mask;

	always_comb begin
		ent_mask = pfx_mask(ent_len);
		key_mask = pfx_mask(key_len);
		hit.exact = ent_valid && (ent_len == key_len) &&
			((ent_addr & key_mask) == (key_addr & key_mask));
		hit.covers = ent_valid && ((ent_addr & ent_mask) == (key_addr & ent_mask));
	end
endmodule

### src/longest_prefix_match_table_top.sv
// IPv4 route table with longest prefix match. Every delete, lookup or get, and every add that does not
// follow an open or refused group, walks the whole entry memory through one prefix compare unit, one
// entry per cycle; an add that finds or makes its route then reads the route's gateways one by one for
// the duplicate check, and a lookup or get reads its route's gateways and emits them as result words.
// An add that follows an open group goes straight to the gateway check. The block takes one word at a
// time and is not ready while an item is at work. Results leave through an output register; a word
// with tlast high closes the results of one item.
`include "longest_prefix_match_table_top_assert.svh"
module longest_prefix_match_table_top #(
	parameter int NUM_ENTRIES = 256,
	parameter int MAX_GW      = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// mode, ip_address, prefix_len, gateway_addr, gateway_vid, zero fill
	input  logic [87:0] s_axis_tdata,
	// more_gateways
	input  logic [0:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status, route_prefix, route_len, next_hop, next_hop_vid, zero fill
	output logic [87:0] m_axis_tdata,
	output logic        m_axis_tlast
);
	import lpm_pkg::*;

	localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int CW = $clog2(NUM_ENTRIES + 1);
	localparam int KW = $clog2(MAX_GW + 1);
	localparam int GD = NUM_ENTRIES * MAX_GW;
	localparam int GA = $clog2(GD);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_ENT_RD, S_ENT_WT, S_GW_RD, S_GW_CHK, S_GW_DONE,
		S_EM_RD, S_EM_WT, S_PUT
	} state_t;

	state_t state_q, after_q;

	logic [1:0]  mode_q;
	logic [31:0] ip_q, gw_q;
	logic [5:0]  len_q;
	logic [11:0] vid_q;
	logic        more_q;

	logic valid_q [NUM_ENTRIES];

	logic [31:0] ent_addr_mem [NUM_ENTRIES];
	logic [5:0]  ent_len_mem  [NUM_ENTRIES];
	logic [KW-1:0] ent_cnt_mem [NUM_ENTRIES];
	logic [31:0] gw_mem  [GD];
	logic [11:0] vid_mem [GD];

	logic [31:0]   rd_addr_q;
	logic [5:0]    rd_len_q;
	logic [KW-1:0] rd_cnt_q;
	logic [31:0]   rd_gw_q;
	logic [11:0]   rd_vid_q;

	logic          cursor_open_q;
	logic [IW-1:0] cursor_q;
	logic          skip_q;

	logic [CW-1:0] iss_q;
	logic          scan_vld_s1;
	logic [IW-1:0] scan_idx_s1;
	logic          scan_ent_s1;

	logic          exact_hit_q;
	logic [IW-1:0] exact_idx_q;
	logic [31:0]   exact_addr_q;
	logic [KW-1:0] exact_cnt_q;
	logic          best_hit_q;
	logic [IW-1:0] best_idx_q;
	logic [31:0]   best_addr_q;
	logic [5:0]    best_len_q;
	logic [KW-1:0] best_cnt_q;
	logic          free_hit_q;
	logic [IW-1:0] free_idx_q;

	logic [IW-1:0] idx_q;
	logic [31:0]   e_addr_q;
	logic [5:0]    e_len_q;
	logic [KW-1:0] e_cnt_q;
	logic [KW-1:0] g_q;
	logic          dup_q;

	logic [2:0]  res_st_q;
	logic [31:0] res_pfx_q, res_hop_q;
	logic [5:0]  res_len_q;
	logic [11:0] res_vid_q;
	logic        res_last_q;

	logic        m_vld_q;
	logic [87:0] out_data_q;
	logic        out_last_q;

	match_t        hit;
	logic [IW-1:0] rd_idx;
	logic [GA-1:0] gw_base;
	logic [GA-1:0] gw_ra;
	logic          scan_more;
	logic [5:0]    in_len;
	logic          alloc_we;
	logic          cnt_we;
	logic [IW-1:0] ent_wi;
	logic [31:0]   ent_wa;
	logic [5:0]    ent_wl;
	logic [KW-1:0] ent_wc;
	logic          gw_last;

	lpm_match u_match (
		.ent_addr (rd_addr_q),
		.ent_len  (rd_len_q),
		.ent_valid(scan_ent_s1),
		.key_addr (ip_q),
		.key_len  (len_q),
		.hit      (hit)
	);

	always_comb begin
		scan_more = iss_q < CW'(NUM_ENTRIES);
		rd_idx = (state_q == S_SCAN) ? iss_q[IW-1:0] : idx_q;
		gw_base = GA'(idx_q) * GA'(MAX_GW);
		gw_ra = gw_base + GA'(g_q);
		in_len = (s_axis_tdata[39:34] > HOST_LEN) ? HOST_LEN : s_axis_tdata[39:34];
		alloc_we = (state_q == S_DECIDE) && (mode_q == MODE_ADD) && !exact_hit_q && free_hit_q;
		cnt_we = (state_q == S_GW_DONE) && !dup_q && (e_cnt_q < KW'(MAX_GW));
		ent_wi = alloc_we ? free_idx_q : idx_q;
		ent_wa = alloc_we ? ((len_q == 6'd0) ? 32'd0 : ip_q) : e_addr_q;
		ent_wl = alloc_we ? len_q : e_len_q;
		ent_wc = alloc_we ? KW'(0) : KW'(e_cnt_q + KW'(1));
		gw_last = (KW'(g_q + KW'(1)) == e_cnt_q);
	end

	// entry and gateway memories, registered reads
	always_ff @(posedge clk) begin
		rd_addr_q <= ent_addr_mem[rd_idx];
		rd_len_q <= ent_len_mem[rd_idx];
		rd_cnt_q <= ent_cnt_mem[rd_idx];
		rd_gw_q <= gw_mem[gw_ra];
		rd_vid_q <= vid_mem[gw_ra];
		if (alloc_we || cnt_we) begin
			ent_addr_mem[ent_wi] <= ent_wa;
			ent_len_mem[ent_wi] <= ent_wl;
			ent_cnt_mem[ent_wi] <= ent_wc;
		end
		if (cnt_we) begin
			gw_mem[gw_base + GA'(e_cnt_q)] <= gw_q;
			vid_mem[gw_base + GA'(e_cnt_q)] <= vid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			after_q <= S_IDLE;
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
			end
			cursor_open_q <= 1'b0;
			skip_q <= 1'b0;
			scan_vld_s1 <= 1'b0;
			m_vld_q <= 1'b0;
		end else begin
			// in S_PUT the output register is reloaded below
			if (m_vld_q && m_axis_tready && (state_q != S_PUT)) begin
				m_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						mode_q <= s_axis_tdata[1:0];
						ip_q <= s_axis_tdata[33:2];
						len_q <= in_len;
						gw_q <= s_axis_tdata[71:40];
						vid_q <= s_axis_tdata[83:72];
						more_q <= s_axis_tuser[0];
						iss_q <= '0;
						scan_vld_s1 <= 1'b0;
						exact_hit_q <= 1'b0;
						best_hit_q <= 1'b0;
						free_hit_q <= 1'b0;
						if (s_axis_tdata[1:0] == MODE_ADD) begin
							if (skip_q) begin
								res_st_q <= ST_EXISTED;
								res_pfx_q <= 32'd0;
								res_len_q <= 6'd0;
								res_hop_q <= s_axis_tdata[71:40];
								res_vid_q <= s_axis_tdata[83:72];
								res_last_q <= 1'b1;
								skip_q <= s_axis_tuser[0];
								cursor_open_q <= 1'b0;
								after_q <= S_IDLE;
								state_q <= S_PUT;
							end else if (cursor_open_q && valid_q[cursor_q]) begin
								idx_q <= cursor_q;
								state_q <= S_ENT_RD;
							end else begin
								state_q <= S_SCAN;
							end
						end else begin
							cursor_open_q <= 1'b0;
							skip_q <= 1'b0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					scan_vld_s1 <= scan_more;
					scan_idx_s1 <= iss_q[IW-1:0];
					scan_ent_s1 <= valid_q[iss_q[IW-1:0]];
					if (scan_more) begin
						iss_q <= CW'(iss_q + CW'(1));
					end
					if (scan_vld_s1) begin
						if (!exact_hit_q && hit.exact) begin
							exact_hit_q <= 1'b1;
							exact_idx_q <= scan_idx_s1;
							exact_addr_q <= rd_addr_q;
							exact_cnt_q <= rd_cnt_q;
						end
						if (hit.covers && (!best_hit_q || (rd_len_q > best_len_q))) begin
							best_hit_q <= 1'b1;
							best_idx_q <= scan_idx_s1;
							best_addr_q <= rd_addr_q;
							best_len_q <= rd_len_q;
							best_cnt_q <= rd_cnt_q;
						end
						if (!free_hit_q && !scan_ent_s1) begin
							free_hit_q <= 1'b1;
							free_idx_q <= scan_idx_s1;
						end
					end
					if (!scan_more && !scan_vld_s1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					res_pfx_q <= 32'd0;
					res_len_q <= 6'd0;
					res_hop_q <= 32'd0;
					res_vid_q <= 12'd0;
					res_last_q <= 1'b1;
					after_q <= S_IDLE;
					g_q <= '0;
					dup_q <= 1'b0;
					case (mode_q)
						MODE_DEL: begin
							if (exact_hit_q) begin
								valid_q[exact_idx_q] <= 1'b0;
							end
							res_st_q <= exact_hit_q ? ST_OK : ST_NOTFOUND;
							state_q <= S_PUT;
						end
						MODE_LOOKUP, MODE_GET: begin
							if ((mode_q == MODE_LOOKUP) ? best_hit_q : exact_hit_q) begin
								if (mode_q == MODE_LOOKUP) begin
									idx_q <= best_idx_q;
									e_addr_q <= best_addr_q;
									e_len_q <= best_len_q;
									e_cnt_q <= best_cnt_q;
								end else begin
									idx_q <= exact_idx_q;
									e_addr_q <= exact_addr_q;
									e_len_q <= len_q;
									e_cnt_q <= exact_cnt_q;
								end
								state_q <= S_EM_RD;
							end else begin
								res_st_q <= ST_NOTFOUND;
								state_q <= S_PUT;
							end
						end
						default: begin
							res_hop_q <= gw_q;
							res_vid_q <= vid_q;
							if (exact_hit_q && (len_q != 6'd0)) begin
								res_st_q <= ST_EXISTED;
								res_pfx_q <= exact_addr_q;
								res_len_q <= len_q;
								skip_q <= more_q;
								cursor_open_q <= 1'b0;
								state_q <= S_PUT;
							end else if (exact_hit_q) begin
								// default route takes more gateways
								idx_q <= exact_idx_q;
								e_addr_q <= exact_addr_q;
								e_len_q <= len_q;
								e_cnt_q <= exact_cnt_q;
								state_q <= S_GW_RD;
							end else if (!free_hit_q) begin
								res_st_q <= ST_FULL;
								skip_q <= more_q;
								cursor_open_q <= 1'b0;
								state_q <= S_PUT;
							end else begin
								valid_q[free_idx_q] <= 1'b1;
								idx_q <= free_idx_q;
								e_addr_q <= ent_wa;
								e_len_q <= len_q;
								e_cnt_q <= '0;
								state_q <= S_GW_RD;
							end
						end
					endcase
				end
				S_ENT_RD: begin
					state_q <= S_ENT_WT;
				end
				S_ENT_WT: begin
					e_addr_q <= rd_addr_q;
					e_len_q <= rd_len_q;
					e_cnt_q <= rd_cnt_q;
					g_q <= '0;
					dup_q <= 1'b0;
					state_q <= S_GW_RD;
				end
				S_GW_RD: begin
					state_q <= (g_q < e_cnt_q) ? S_GW_CHK : S_GW_DONE;
				end
				S_GW_CHK: begin
					if (rd_gw_q == gw_q) begin
						dup_q <= 1'b1;
					end
					g_q <= KW'(g_q + KW'(1));
					state_q <= S_GW_RD;
				end
				S_GW_DONE: begin
					if (dup_q) begin
						res_st_q <= ST_DUP;
					end else if (e_cnt_q >= KW'(MAX_GW)) begin
						res_st_q <= ST_FULL;
					end else begin
						res_st_q <= ST_OK;
					end
					res_pfx_q <= e_addr_q;
					res_len_q <= e_len_q;
					res_hop_q <= gw_q;
					res_vid_q <= vid_q;
					res_last_q <= 1'b1;
					cursor_open_q <= more_q;
					cursor_q <= idx_q;
					skip_q <= 1'b0;
					after_q <= S_IDLE;
					state_q <= S_PUT;
				end
				S_EM_RD: begin
					if (e_cnt_q == '0) begin
						res_st_q <= ST_OK;
						res_pfx_q <= e_addr_q;
						res_len_q <= e_len_q;
						res_hop_q <= 32'd0;
						res_vid_q <= 12'd0;
						res_last_q <= 1'b1;
						after_q <= S_IDLE;
						state_q <= S_PUT;
					end else begin
						state_q <= S_EM_WT;
					end
				end
				S_EM_WT: begin
					res_st_q <= ST_OK;
					res_vid_q <= rd_vid_q;
					// connected route answers with the destination itself
					if ((mode_q == MODE_LOOKUP) && (e_cnt_q == KW'(1)) && (rd_gw_q == 32'd0) &&
						(e_len_q != 6'd0)) begin
						res_pfx_q <= ip_q;
						res_len_q <= HOST_LEN;
						res_hop_q <= ip_q;
						res_last_q <= 1'b1;
						after_q <= S_IDLE;
					end else begin
						res_pfx_q <= e_addr_q;
						res_len_q <= e_len_q;
						res_hop_q <= rd_gw_q;
						res_last_q <= gw_last;
						after_q <= gw_last ? S_IDLE : S_EM_RD;
					end
					g_q <= KW'(g_q + KW'(1));
					state_q <= S_PUT;
				end
				S_PUT: begin
					if (!m_vld_q || m_axis_tready) begin
						m_vld_q <= 1'b1;
						out_data_q <= {3'd0, res_vid_q, res_hop_q, res_len_q, res_pfx_q, res_st_q};
						out_last_q <= res_last_q;
						state_q <= after_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tlast = out_last_q;

	`LPM_NEVER(a_skip_with_open_group, clk, arst_n, skip_q && cursor_open_q)
	`LPM_ASSERT(a_open_group_valid, clk, arst_n, cursor_open_q |-> valid_q[cursor_q])
	`LPM_ASSERT(a_accept_leaves_idle, clk, arst_n, (s_axis_tvalid && s_axis_tready) |=> (state_q != S_IDLE))
endmodule

### bench/longest_prefix_match_table_top_test.sv
// self-checking testbench for the longest prefix match route table
module longest_prefix_match_table_top_test;
	import lpm_pkg::*;

	localparam int NUM_ENTRIES = 256;
	localparam int MAX_GW      = 8;
	localparam int IDLE_LIMIT  = 20000;
	localparam int DRAIN_WAIT  = NUM_ENTRIES + 64;
	localparam int NO_ENTRY    = NUM_ENTRIES;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] ip;
		logic [5:0]  len;
		logic [31:0] gw;
		logic [11:0] vid;
		logic        more;
	} route_cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] prefix;
		logic [5:0]  len;
		logic [31:0] hop;
		logic [11:0] vid;
		logic        last;
	} route_res_t;

	typedef struct {
		route_cmd_t cmd;
		bit         typed;
		route_res_t res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [87:0] m_axis_tdata;
	logic        m_axis_tlast;

	longest_prefix_match_table_top #(
		.NUM_ENTRIES(NUM_ENTRIES),
		.MAX_GW(MAX_GW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	// shadow copy of the route table
	bit          tbl_valid [NUM_ENTRIES];
	logic [31:0] tbl_addr [NUM_ENTRIES];
	logic [5:0]  tbl_len [NUM_ENTRIES];
	int          tbl_gw_cnt [NUM_ENTRIES];
	logic [31:0] tbl_gw [NUM_ENTRIES*MAX_GW];
	logic [11:0] tbl_vid [NUM_ENTRIES*MAX_GW];
	int          open_route;
	bit          skip_group;

	route_res_t route_expect_q[$];
	int         mismatches;
	int         idle_cycles;
	int         results_seen;
	stim_row_t  rows[$];

	always #5 clk = ~clk;

	function automatic logic [31:0] route_mask(input logic [5:0] len);
		if (len == 6'd0) return 32'd0;
		return 32'hFFFF_FFFF << (32 - len);
	endfunction

	function automatic int find_route(input logic [31:0] ip, input logic [5:0] len);
		logic [31:0] m;
		m = route_mask(len);
		for (int i = 0; i < NUM_ENTRIES; i++)
			if (tbl_valid[i] && tbl_len[i] == len && (tbl_addr[i] & m) == (ip & m))
				return i;
		return NO_ENTRY;
	endfunction

	function automatic int find_best(input logic [31:0] ip);
		int best;
		logic [31:0] m;
		best = NO_ENTRY;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			m = route_mask(tbl_len[i]);
			if (tbl_valid[i] && (tbl_addr[i] & m) == (ip & m) &&
					(best == NO_ENTRY || tbl_len[i] > tbl_len[best]))
				best = i;
		end
		return best;
	endfunction

	function automatic route_res_t mk_res(input logic [2:0] st, input logic [31:0] pfx,
			input logic [5:0] len, input logic [31:0] hop, input logic [11:0] vid,
			input logic last);
		route_res_t r;
		r.status = st; r.prefix = pfx; r.len = len; r.hop = hop; r.vid = vid; r.last = last;
		return r;
	endfunction

	function automatic route_cmd_t mk_cmd(input logic [1:0] mode, input logic [31:0] ip,
			input logic [5:0] len, input logic [31:0] gw, input logic [11:0] vid,
			input logic more);
		route_cmd_t c;
		c.mode = mode; c.ip = ip; c.len = len; c.gw = gw; c.vid = vid; c.more = more;
		return c;
	endfunction

	function automatic void predict_gateway_add(input route_cmd_t c, input logic [5:0] len,
			ref route_res_t out[$]);
		int idx, base;
		logic [2:0] st;
		st = ST_OK;
		if (skip_group) begin
			skip_group = c.more;
			open_route = NO_ENTRY;
			out.push_back(mk_res(ST_EXISTED, 0, 0, c.gw, c.vid, 1'b1));
			return;
		end
		if (open_route != NO_ENTRY && tbl_valid[open_route]) begin
			idx = open_route;
		end else begin
			idx = find_route(c.ip, len);
			if (idx != NO_ENTRY && len != 0) begin
				skip_group = c.more;
				open_route = NO_ENTRY;
				out.push_back(mk_res(ST_EXISTED, tbl_addr[idx], tbl_len[idx], c.gw, c.vid, 1'b1));
				return;
			end
			if (idx == NO_ENTRY) begin
				for (idx = 0; idx < NUM_ENTRIES; idx++)
					if (!tbl_valid[idx]) break;
				if (idx == NUM_ENTRIES) begin
					skip_group = c.more;
					open_route = NO_ENTRY;
					out.push_back(mk_res(ST_FULL, 0, 0, c.gw, c.vid, 1'b1));
					return;
				end
				tbl_valid[idx] = 1;
				tbl_addr[idx] = (len == 0) ? 32'd0 : c.ip;
				tbl_len[idx] = len;
				tbl_gw_cnt[idx] = 0;
			end
		end
		base = idx * MAX_GW;
		for (int g = 0; g < tbl_gw_cnt[idx]; g++)
			if (tbl_gw[base+g] == c.gw) st = ST_DUP;
		if (st == ST_OK) begin
			if (tbl_gw_cnt[idx] >= MAX_GW) begin
				st = ST_FULL;
			end else begin
				tbl_gw[base+tbl_gw_cnt[idx]] = c.gw;
				tbl_vid[base+tbl_gw_cnt[idx]] = c.vid;
				tbl_gw_cnt[idx]++;
			end
		end
		open_route = c.more ? idx : NO_ENTRY;
		skip_group = 0;
		out.push_back(mk_res(st, tbl_addr[idx], tbl_len[idx], c.gw, c.vid, 1'b1));
	endfunction

	// expected results of one accepted word, table state updated on the way
	function automatic void predict_route_op(input route_cmd_t c, ref route_res_t out[$]);
		logic [5:0] len;
		int idx, base, cnt;
		len = (c.len > 6'd32) ? 6'd32 : c.len;
		if (c.mode == MODE_ADD) begin
			predict_gateway_add(c, len, out);
			return;
		end
		open_route = NO_ENTRY;
		skip_group = 0;
		if (c.mode == MODE_DEL) begin
			idx = find_route(c.ip, len);
			if (idx != NO_ENTRY) tbl_valid[idx] = 0;
			out.push_back(mk_res(idx != NO_ENTRY ? ST_OK : ST_NOTFOUND, 0, 0, 0, 0, 1'b1));
			return;
		end
		idx = (c.mode == MODE_LOOKUP) ? find_best(c.ip) : find_route(c.ip, len);
		if (idx == NO_ENTRY) begin
			out.push_back(mk_res(ST_NOTFOUND, 0, 0, 0, 0, 1'b1));
			return;
		end
		base = idx * MAX_GW;
		cnt = tbl_gw_cnt[idx];
		if (c.mode == MODE_LOOKUP && cnt == 1 && tbl_gw[base] == 0 && tbl_len[idx] != 0) begin
			// connected route answers with the destination itself
			out.push_back(mk_res(ST_OK, c.ip, HOST_LEN, c.ip, tbl_vid[base], 1'b1));
		end else if (cnt == 0) begin
			out.push_back(mk_res(ST_OK, tbl_addr[idx], tbl_len[idx], 0, 0, 1'b1));
		end else begin
			for (int g = 0; g < cnt; g++)
				out.push_back(mk_res(ST_OK, tbl_addr[idx], tbl_len[idx], tbl_gw[base+g],
					tbl_vid[base+g], g + 1 == cnt));
		end
	endfunction

	task automatic send_word(input route_cmd_t c, input bit typed, input route_res_t want);
		route_res_t got[$];
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		if ($urandom_range(0, 24) == 0) gap = $urandom_range(20, 120);
		repeat (gap) @(negedge clk);
		s_axis_tdata = {4'd0, c.vid, c.gw, c.len, c.ip, c.mode};
		s_axis_tuser = c.more;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		predict_route_op(c, got);
		if (typed) got[0] = want;
		foreach (got[i]) route_expect_q.push_back(got[i]);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic send_cmd(input route_cmd_t c);
		send_word(c, 1'b0, '0);
	endtask

	function automatic logic [31:0] pick_addr();
		logic [31:0] pool [8];
		pool = '{32'h0A00_0000, 32'hC0A8_0100, 32'hAC10_0000, 32'h0000_0000,
			32'hFFFF_FFFF, 32'h0A0A_0A0A, 32'h8000_0000, 32'hC0A8_01FF};
		if ($urandom_range(0, 4) == 0) return $urandom;
		return pool[$urandom_range(0, 7)] ^ ($urandom_range(0, 1) ? 32'd0 : $urandom_range(0, 255));
	endfunction

	function automatic logic [5:0] pick_len();
		logic [5:0] lens [6];
		lens = '{6'd0, 6'd8, 6'd16, 6'd24, 6'd32, 6'd12};
		if ($urandom_range(0, 5) == 0) return $urandom_range(0, 63);
		return lens[$urandom_range(0, 5)];
	endfunction

	function automatic logic [31:0] pick_gw();
		case ($urandom_range(0, 3))
			0: return 32'd0;
			1: return $urandom;
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	// receiver: random back-pressure plus one long hold-off
	initial begin
		int stall;
		bit held;
		m_axis_tready = 1'b0;
		held = 0;
		forever begin
			@(negedge clk);
			if (!held && results_seen >= 60) begin
				held = 1;
				m_axis_tready = 1'b0;
				repeat (3000) @(negedge clk);
			end
			if ($urandom_range(0, 9) < 3) begin
				m_axis_tready = 1'b0;
				stall = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
				repeat (stall - 1) @(negedge clk);
			end else begin
				m_axis_tready = 1'b1;
				if ($urandom_range(0, 3) == 0) repeat ($urandom_range(5, 30)) @(negedge clk);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		route_res_t act, exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			act = mk_res(m_axis_tdata[2:0], m_axis_tdata[34:3], m_axis_tdata[40:35],
				m_axis_tdata[72:41], m_axis_tdata[84:73], m_axis_tlast);
			if (route_expect_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: st=%0d pfx=%h len=%0d hop=%h vid=%h last=%b",
						act.status, act.prefix, act.len, act.hop, act.vid, act.last);
			end else begin
				exp_r = route_expect_q.pop_front();
				if (act !== exp_r) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp st=%0d pfx=%h len=%0d hop=%h vid=%h last=%b",
							exp_r.status, exp_r.prefix, exp_r.len, exp_r.hop, exp_r.vid,
							exp_r.last);
						$display("          got st=%0d pfx=%h len=%0d hop=%h vid=%h last=%b",
							act.status, act.prefix, act.len, act.hop, act.vid, act.last);
					end
				end
			end
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		route_cmd_t c;
		int n, nr;
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		mismatches = 0;
		idle_cycles = 0;
		results_seen = 0;
		open_route = NO_ENTRY;
		skip_group = 0;
		foreach (tbl_valid[i]) tbl_valid[i] = 0;

		// directed rows; typed results only where obvious
		rows.push_back('{mk_cmd(MODE_LOOKUP, 32'h0, 0, 0, 0, 0), 1,
			mk_res(ST_NOTFOUND, 0, 0, 0, 0, 1)});
		rows.push_back('{mk_cmd(MODE_GET, 32'hFFFF_FFFF, 32, 32'hFFFF_FFFF, 12'hFFF, 1), 1,
			mk_res(ST_NOTFOUND, 0, 0, 0, 0, 1)});
		rows.push_back('{mk_cmd(MODE_DEL, 32'h0, 0, 0, 0, 0), 1,
			mk_res(ST_NOTFOUND, 0, 0, 0, 0, 1)});
		rows.push_back('{mk_cmd(MODE_ADD, 32'h0A00_0000, 8, 32'd1, 12'd0, 1), 0, '0});
		rows.push_back('{mk_cmd(MODE_ADD, 32'h5555_5555, 3, 32'hFFFF_FFFF, 12'hFFF, 1), 0, '0});
		rows.push_back('{mk_cmd(MODE_ADD, 32'h0, 0, 32'd1, 12'h123, 0), 1,
			mk_res(ST_DUP, 32'h0A00_0000, 8, 32'd1, 12'h123, 1)});
		rows.push_back('{mk_cmd(MODE_ADD, 32'h0, 0, 32'd0, 12'd5, 0), 0, '0});
		rows.push_back('{mk_cmd(MODE_ADD, 32'hDEAD_BEEF, 0, 32'd2, 12'd6, 0), 0, '0});
		rows.push_back('{mk_cmd(MODE_ADD, 32'h0AFF_FFFF, 8, 32'd7, 12'd7, 1), 0, '0});
		rows.push_back('{mk_cmd(MODE_ADD, 32'h0, 0, 32'd8, 12'd8, 0), 1,
			mk_res(ST_EXISTED, 0, 0, 32'd8, 12'd8, 1)});
		rows.push_back('{mk_cmd(MODE_ADD, 32'hC0A8_0100, 24, 32'd0, 12'd9, 0), 0, '0});
		rows.push_back('{mk_cmd(MODE_LOOKUP, 32'hC0A8_014D, 0, 0, 0, 0), 0, '0});
		rows.push_back('{mk_cmd(MODE_LOOKUP, 32'h0A01_0203, 17, 0, 0, 0), 0, '0});
		rows.push_back('{mk_cmd(MODE_LOOKUP, 32'h0B00_0000, 0, 0, 0, 0), 0, '0});
		rows.push_back('{mk_cmd(MODE_GET, 32'h0A00_0000, 8, 0, 0, 0), 0, '0});
		rows.push_back('{mk_cmd(MODE_GET, 32'hC0A8_0100, 24, 0, 0, 0), 0, '0});
		rows.push_back('{mk_cmd(MODE_ADD, 32'hFFFF_FFFF, 63, 32'd3, 12'hAAA, 0), 0, '0});
		rows.push_back('{mk_cmd(MODE_GET, 32'hFFFF_FFFF, 40, 0, 0, 0), 0, '0});
		rows.push_back('{mk_cmd(MODE_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 0), 0, '0});
		rows.push_back('{mk_cmd(MODE_DEL, 32'h0A12_3456, 8, 0, 0, 0), 1,
			mk_res(ST_OK, 0, 0, 0, 0, 1)});
		rows.push_back('{mk_cmd(MODE_LOOKUP, 32'h0A01_0203, 0, 0, 0, 0), 0, '0});
		rows.push_back('{mk_cmd(MODE_GET, 32'h1234_5678, 0, 0, 0, 0), 0, '0});
		rows.push_back('{mk_cmd(MODE_DEL, 32'h0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{mk_cmd(MODE_LOOKUP, 32'h0B00_0000, 0, 0, 0, 0), 0, '0});

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) send_word(rows[i].cmd, rows[i].typed, rows[i].res);

		// sender pause until the table has answered everything
		wait (route_expect_q.size() == 0);
		repeat (DRAIN_WAIT) @(negedge clk);

		// fill the table until it reports full, free a quarter, overflow one gateway list
		n = 0;
		for (int i = 0; i < NUM_ENTRIES + 2; i++)
			send_cmd(mk_cmd(MODE_ADD, 32'hC000_0000 | i, 32, i + 1, i, 0));
		send_cmd(mk_cmd(MODE_LOOKUP, 32'hC000_0005, 0, 0, 0, 0));
		for (int i = 0; i < NUM_ENTRIES / 4; i++)
			send_cmd(mk_cmd(MODE_DEL, 32'hC000_0000 | i, 32, 0, 0, 0));
		for (int g = 0; g < MAX_GW + 2; g++)
			send_cmd(mk_cmd(MODE_ADD, 32'hAC10_0000, 12, g + 100, g, g != MAX_GW + 1));
		send_cmd(mk_cmd(MODE_LOOKUP, 32'hAC1F_FFFF, 0, 0, 0, 0));

		// random traffic: mostly well-formed add groups and lookups
		while (n < 90) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					nr = $urandom_range(1, 10);
					c = mk_cmd(MODE_ADD, pick_addr(), pick_len(), 0, 0, 0);
					for (int g = 0; g < nr; g++) begin
						c.gw = pick_gw();
						c.vid = $urandom_range(0, 4095);
						c.more = (g != nr - 1) || ($urandom_range(0, 7) == 0);
						if ($urandom_range(0, 9) == 0) c.ip = $urandom;
						send_cmd(c);
						n++;
					end
				end
				4, 5, 6: begin
					send_cmd(mk_cmd(MODE_LOOKUP, pick_addr(), $urandom_range(0, 63), $urandom,
						$urandom_range(0, 4095), $urandom_range(0, 1)));
					n++;
				end
				7, 8: begin
					send_cmd(mk_cmd(MODE_GET, pick_addr(), pick_len(), $urandom,
						$urandom_range(0, 4095), $urandom_range(0, 1)));
					n++;
				end
				default: begin
					send_cmd(mk_cmd(MODE_DEL, pick_addr(), pick_len(), $urandom,
						$urandom_range(0, 4095), $urandom_range(0, 1)));
					n++;
				end
			endcase
		end

		wait (route_expect_q.size() == 0);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (mismatches == 0 && route_expect_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

### filelist.f
+incdir+src
src/lpm_pkg.sv
src/lpm_match.sv
src/longest_prefix_match_table_top.sv
bench/longest_prefix_match_table_top_test.sv
